// ===== rtl/linear_scan_priority_queue_assert.svh =====
// Assertion macros for the linear scan priority queue.
// Depends on a clock named aclk and an active-low reset named aresetn in the user module.
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_ASSERT_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define LSPQ_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("lspq: assertion failed");

// Check a property on every clock edge, reset included
`define LSPQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("lspq: assertion failed");

`else

`define LSPQ_ASSERT(label, prop)
`define LSPQ_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== rtl/lspq_pkg.sv =====
// Shared types and constants for the linear scan priority queue.
// No dependencies.
`timescale 1ns / 1ps

package lspq_pkg;

    // Storage geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 2 * DATA_W;
    localparam int CMD_W   = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Reset value of the capacity register
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/linear_scan_priority_queue.sv =====
// Linear scan priority queue: top level with the entry memory and its sequencer.
// Depends on lspq_pkg and linear_scan_priority_queue_assert.svh.
`timescale 1ns / 1ps
`include "linear_scan_priority_queue_assert.svh"

// Bounded priority queue of up to 16 value/priority pairs kept in arrival order in
// one 16 x 64 memory (one write and one read port, registered read). Command 0 pushes
// a pair at the tail unless the queue holds the effective capacity (the capacity
// register clamped to 1..16); command 1 pops the entry with the largest signed
// priority, oldest first on ties, and reports it; command 2 empties the queue.
// Every command returns one result with occupancy, empty and full after it.
// Sequence: an item is taken in IDLE and executed in EXEC; push, clear and a pop
// on an empty queue finish in EXEC once the output register is free. A pop of a
// non-empty queue starts the read at the head in EXEC, then the single read port
// scans one entry per cycle in SCAN, moves the entries after the winner toward
// the head one per cycle in SHIFT, and FINISH reports the result once the output
// register is free. A finished result waits in the output register
// while the next item is taken; a second result stalls until the first transfers.
// Write capacity only while the queue is idle.
module linear_scan_priority_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [lspq_pkg::CNT_W-1:0]    cfg_wr_data,
    // command channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lspq_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [lspq_pkg::DATA_W-1:0] s_value,
    input  logic signed [lspq_pkg::DATA_W-1:0] s_priority_req,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_done_res,
    output logic signed [lspq_pkg::DATA_W-1:0] m_out_value,
    output logic signed [lspq_pkg::DATA_W-1:0] m_out_priority,
    output logic [lspq_pkg::CNT_W-1:0]    m_occupancy,
    output logic                          m_is_empty,
    output logic                          m_is_full
);

    localparam int IDX_W  = lspq_pkg::IDX_W;
    localparam int CNT_W  = lspq_pkg::CNT_W;
    localparam int DATA_W = lspq_pkg::DATA_W;

    lspq_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [lspq_pkg::CMD_W-1:0] cmd_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] pri_reg;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [DATA_W-1:0] best_val_reg, best_val_next;
    logic [DATA_W-1:0] best_pri_reg, best_pri_next;

    // memory ports
    logic [lspq_pkg::ENTRY_W-1:0] mem [lspq_pkg::DEPTH];
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [lspq_pkg::ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]             mem_raddr;
    logic [lspq_pkg::ENTRY_W-1:0] rd_data_reg;
    logic [DATA_W-1:0]            rd_val;
    logic [DATA_W-1:0]            rd_pri;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic              load_res;
    logic              out_free;
    logic              done_next;
    logic [DATA_W-1:0] ov_next;
    logic [DATA_W-1:0] op_next;
    logic              done_reg;
    logic [DATA_W-1:0] ov_reg;
    logic [DATA_W-1:0] op_reg;
    logic [CNT_W-1:0]  occ_reg;
    logic              empty_reg;
    logic              full_reg;

    logic              take_best;
    logic              in_xfer;

    assign rd_val   = rd_data_reg[lspq_pkg::ENTRY_W-1:DATA_W];
    assign rd_pri   = rd_data_reg[DATA_W-1:0];
    assign s_ready  = (state_reg == lspq_pkg::ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Clamp the capacity register to 1..DEPTH
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_reg > CNT_W'(lspq_pkg::DEPTH)) begin
            eff_cap = CNT_W'(lspq_pkg::DEPTH);
        end else begin
            eff_cap = cap_reg;
        end
    end

    // Entry memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Sequencer: execute, scan for the winner, shift the tail down, report
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        best_pri_next = best_pri_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_raddr     = '0;
        load_res      = 1'b0;
        done_next     = 1'b0;
        ov_next       = '0;
        op_next       = '0;
        take_best     = 1'b0;

        case (state_reg)
            lspq_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = lspq_pkg::ST_EXEC;
                end
            end

            lspq_pkg::ST_EXEC: begin
                if (cmd_reg == lspq_pkg::CMD_POP && count_reg != '0) begin
                    // start the scan at the head
                    mem_raddr  = '0;
                    idx_next   = '0;
                    state_next = lspq_pkg::ST_SCAN;
                end else if (out_free) begin
                    case (cmd_reg)
                        lspq_pkg::CMD_PUSH: begin
                            if (count_reg < eff_cap) begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                mem_wdata  = {val_reg, pri_reg};
                                count_next = count_reg + CNT_W'(1);
                                done_next  = 1'b1;
                            end
                        end
                        lspq_pkg::CMD_CLEAR: begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default: begin
                            done_next = 1'b0;
                        end
                    endcase
                    load_res   = 1'b1;
                    state_next = lspq_pkg::ST_IDLE;
                end
            end

            lspq_pkg::ST_SCAN: begin
                // strictly greater keeps the oldest entry on ties
                take_best = (idx_reg == '0) || ($signed(rd_pri) > $signed(best_pri_reg));
                if (take_best) begin
                    best_idx_next = idx_reg;
                    best_val_next = rd_val;
                    best_pri_next = rd_pri;
                end
                if (CNT_W'(idx_reg) + CNT_W'(1) < count_reg) begin
                    mem_raddr = idx_reg + IDX_W'(1);
                    idx_next  = idx_reg + IDX_W'(1);
                end else if (CNT_W'(best_idx_next) + CNT_W'(1) < count_reg) begin
                    // fetch the entry after the winner to start the shift
                    mem_raddr  = best_idx_next + IDX_W'(1);
                    idx_next   = best_idx_next;
                    state_next = lspq_pkg::ST_SHIFT;
                end else begin
                    state_next = lspq_pkg::ST_FINISH;
                end
            end

            lspq_pkg::ST_SHIFT: begin
                // read address always runs ahead of the write address: no overlap
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rd_data_reg;
                if (CNT_W'(idx_reg) + CNT_W'(2) < count_reg) begin
                    mem_raddr = idx_reg + IDX_W'(2);
                    idx_next  = idx_reg + IDX_W'(1);
                end else begin
                    state_next = lspq_pkg::ST_FINISH;
                end
            end

            lspq_pkg::ST_FINISH: begin
                if (out_free) begin
                    count_next = count_reg - CNT_W'(1);
                    done_next  = 1'b1;
                    ov_next    = best_val_reg;
                    op_next    = best_pri_reg;
                    load_res   = 1'b1;
                    state_next = lspq_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lspq_pkg::ST_IDLE;
            end
        endcase

        // hold the result until the transfer on the result side
        if (load_res) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lspq_pkg::ST_IDLE;
            count_reg   <= '0;
            cap_reg     <= lspq_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg <= s_cmd;
            val_reg <= s_value;
            pri_reg <= s_priority_req;
        end
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        best_pri_reg <= best_pri_next;
        if (load_res) begin
            done_reg  <= done_next;
            ov_reg    <= ov_next;
            op_reg    <= op_next;
            occ_reg   <= count_next;
            empty_reg <= (count_next == '0);
            full_reg  <= (count_next >= eff_cap);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_done_res     = done_reg;
    assign m_out_value    = ov_reg;
    assign m_out_priority = op_reg;
    assign m_occupancy    = occ_reg;
    assign m_is_empty     = empty_reg;
    assign m_is_full      = full_reg;

    // Checks
    `LSPQ_ASSERT(a_count_range, count_reg <= CNT_W'(lspq_pkg::DEPTH))
    `LSPQ_ASSERT(a_scan_in_range, state_reg == lspq_pkg::ST_SCAN |-> CNT_W'(idx_reg) < count_reg)
    `LSPQ_ASSERT(a_shift_src_held, state_reg == lspq_pkg::ST_SHIFT |-> CNT_W'(idx_reg) + CNT_W'(1) < count_reg)
    `LSPQ_ASSERT(a_pop_removes_one, (state_reg == lspq_pkg::ST_FINISH && out_free) |=> (count_reg == $past(count_reg) - CNT_W'(1)) && m_valid_reg)

endmodule

// ===== test/lspq_queue_checker.sv =====
// Result checker for the linear scan priority queue testbench.
// Depends on lspq_pkg; watches the command, result and capacity ports of the queue.
`timescale 1ns / 1ps

module lspq_queue_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lspq_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [lspq_pkg::CMD_W-1:0]        s_cmd,
    input  logic signed [lspq_pkg::DATA_W-1:0] s_value,
    input  logic signed [lspq_pkg::DATA_W-1:0] s_priority_req,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_done_res,
    input  logic signed [lspq_pkg::DATA_W-1:0] m_out_value,
    input  logic signed [lspq_pkg::DATA_W-1:0] m_out_priority,
    input  logic [lspq_pkg::CNT_W-1:0]        m_occupancy,
    input  logic                              m_is_empty,
    input  logic                              m_is_full,
    output int                                error_count,
    output int                                replies_outstanding
);
    localparam int CMD_W  = lspq_pkg::CMD_W;
    localparam int CNT_W  = lspq_pkg::CNT_W;
    localparam int DATA_W = lspq_pkg::DATA_W;
    localparam int DEPTH  = lspq_pkg::DEPTH;

    typedef struct {
        logic                     done;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
        logic [CNT_W-1:0]         occupancy;
        logic                     empty;
        logic                     full;
    } queue_reply_t;

    // Shadow copy of the queue contents, kept in arrival order
    logic signed [DATA_W-1:0] held_value [DEPTH];
    logic signed [DATA_W-1:0] held_prio  [DEPTH];
    int                       held_count;
    logic [CNT_W-1:0]         cap_setting;

    queue_reply_t predicted_replies [$];
    int           mismatch_total;

    // Clamp the capacity register to 1..DEPTH
    function automatic int effective_capacity();
        if (cap_setting == 0)
            return 1;
        if (cap_setting > DEPTH)
            return DEPTH;
        return int'(cap_setting);
    endfunction

    // Apply one command to the shadow queue and return the reply it produces
    function automatic queue_reply_t predict_queue_op(
        input logic [CMD_W-1:0]        cmd,
        input logic signed [DATA_W-1:0] value,
        input logic signed [DATA_W-1:0] prio
    );
        queue_reply_t reply;
        int           cap;
        int           best;

        cap = effective_capacity();
        reply.done  = 1'b0;
        reply.value = '0;
        reply.prio  = '0;
        case (cmd)
            lspq_pkg::CMD_PUSH: begin
                if (held_count < cap) begin
                    held_value[held_count] = value;
                    held_prio[held_count]  = prio;
                    held_count++;
                    reply.done = 1'b1;
                end
            end
            lspq_pkg::CMD_POP: begin
                if (held_count > 0) begin
                    // strict compare keeps the oldest entry on ties
                    best = 0;
                    for (int i = 1; i < held_count; i++)
                        if (held_prio[i] > held_prio[best])
                            best = i;
                    reply.value = held_value[best];
                    reply.prio  = held_prio[best];
                    // close the gap toward the head
                    for (int i = best; i < held_count - 1; i++) begin
                        held_value[i] = held_value[i + 1];
                        held_prio[i]  = held_prio[i + 1];
                    end
                    held_count--;
                    reply.done = 1'b1;
                end
            end
            lspq_pkg::CMD_CLEAR: begin
                held_count = 0;
                reply.done = 1'b1;
            end
            default: ;
        endcase
        reply.occupancy = CNT_W'(held_count);
        reply.empty     = (held_count == 0);
        reply.full      = (held_count >= cap);
        return reply;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatch_total++;
            $display("%0t lspq: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Track capacity writes, predict on input transfers, compare on output transfers
    always @(posedge aclk) begin
        queue_reply_t want;

        if (!aresetn) begin
            held_count  = 0;
            cap_setting = lspq_pkg::CAP_RESET;
            predicted_replies.delete();
            mismatch_total = 0;
        end else begin
            if (cfg_wr_en)
                cap_setting = cfg_wr_data;
            if (s_valid && s_ready)
                predicted_replies.push_back(predict_queue_op(s_cmd, s_value, s_priority_req));
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    mismatch_total++;
                    $display(
                        "%0t lspq: expected no result, actual done=%0d value=%0d prio=%0d occ=%0d",
                        $time, m_done_res, m_out_value, m_out_priority, m_occupancy);
                end else begin
                    want = predicted_replies.pop_front();
                    check_field("done_res", want.done, m_done_res);
                    check_field("out_value", want.value, m_out_value);
                    check_field("out_priority", want.prio, m_out_priority);
                    check_field("occupancy", want.occupancy, m_occupancy);
                    check_field("is_empty", want.empty, m_is_empty);
                    check_field("is_full", want.full, m_is_full);
                end
            end
        end
        error_count         <= mismatch_total;
        replies_outstanding <= predicted_replies.size();
    end

endmodule

// ===== test/tb_linear_scan_priority_queue.sv =====
// Testbench top for the linear scan priority queue: stimulus, stalls and verdict.
// Depends on lspq_pkg, linear_scan_priority_queue and lspq_queue_checker.
`timescale 1ns / 1ps

module tb_linear_scan_priority_queue;
    localparam int                    CMD_W         = lspq_pkg::CMD_W;
    localparam int                    CNT_W         = lspq_pkg::CNT_W;
    localparam int                    DATA_W        = lspq_pkg::DATA_W;
    localparam int                    DEPTH         = lspq_pkg::DEPTH;
    localparam logic [CMD_W-1:0]      CMD_NOP       = 2'd3;
    localparam logic signed [DATA_W-1:0] S_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S_MIN      = 32'sh8000_0000;
    localparam int                    STALL_LIMIT   = 2000;
    localparam int                    HOLD_LEN      = 300;
    localparam int                    RANDOM_PHASES = 12;
    localparam int                    PHASE_ITEMS   = 106;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     cfg_wr_en      = 1'b0;
    logic [CNT_W-1:0]         cfg_wr_data    = '0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd          = lspq_pkg::CMD_PUSH;
    logic signed [DATA_W-1:0] s_value        = '0;
    logic signed [DATA_W-1:0] s_priority_req = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic                     m_done_res;
    logic signed [DATA_W-1:0] m_out_value;
    logic signed [DATA_W-1:0] m_out_priority;
    logic [CNT_W-1:0]         m_occupancy;
    logic                     m_is_empty;
    logic                     m_is_full;

    int   error_count;
    int   replies_outstanding;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    logic hold_req      = 1'b0;
    int   quiet_cycles  = 0;

    logic [CNT_W-1:0] phase_caps [RANDOM_PHASES] = '{
        5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd2, 5'd16, 5'd12, 5'd17, 5'd4, 5'd16, 5'd9
    };

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    linear_scan_priority_queue dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_value        (s_value),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_done_res     (m_done_res),
        .m_out_value    (m_out_value),
        .m_out_priority (m_out_priority),
        .m_occupancy    (m_occupancy),
        .m_is_empty     (m_is_empty),
        .m_is_full      (m_is_full)
    );

    lspq_queue_checker u_queue_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_value             (s_value),
        .s_priority_req      (s_priority_req),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_done_res          (m_done_res),
        .m_out_value         (m_out_value),
        .m_out_priority      (m_out_priority),
        .m_occupancy         (m_occupancy),
        .m_is_empty          (m_is_empty),
        .m_is_full           (m_is_full),
        .error_count         (error_count),
        .replies_outstanding (replies_outstanding)
    );

    // Offer one command, idling first at the current rate, and hold it until the transfer
    task automatic send_item(
        input logic [CMD_W-1:0]         cmd,
        input logic signed [DATA_W-1:0] value,
        input logic signed [DATA_W-1:0] prio
    );
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_value        <= value;
        s_priority_req <= prio;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (replies_outstanding != 0);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(15))
            0:       return S_MIN;
            1:       return S_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Favor a narrow band of priorities so ties are common
    function automatic logic signed [DATA_W-1:0] random_priority();
        logic signed [DATA_W-1:0] band;

        band = $urandom_range(3);
        case ($urandom_range(9))
            0:          return S_MAX;
            1:          return S_MIN;
            2, 3, 4, 5: return band - 1;
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] random_cmd(input int push_pct);
        int r;

        r = $urandom_range(99);
        if (r < push_pct)
            return lspq_pkg::CMD_PUSH;
        if (r < 95)
            return lspq_pkg::CMD_POP;
        if (r < 98)
            return lspq_pkg::CMD_CLEAR;
        return CMD_NOP;
    endfunction

    // Result side: random stalls, plus one long hold-off when requested
    initial begin
        bit hold_taken;

        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end else begin
                if (!hold_req)
                    hold_taken = 1'b0;
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Count cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        do @(posedge aclk); while (quiet_cycles < STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int push_pct;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct  = 23;
        sink_idle_pct = 61;

        // Empty-queue corners and the unused command
        send_item(lspq_pkg::CMD_POP, 32'sd5, 32'sd5);
        send_item(lspq_pkg::CMD_CLEAR, '0, '0);
        send_item(CMD_NOP, S_MAX, S_MAX);
        // Extremes of value and priority, then a tie on priority 7
        send_item(lspq_pkg::CMD_PUSH, S_MAX, S_MIN);
        send_item(lspq_pkg::CMD_PUSH, S_MIN, S_MAX);
        send_item(lspq_pkg::CMD_PUSH, 32'sd0, -32'sd1);
        send_item(lspq_pkg::CMD_PUSH, -32'sd1, 32'sd0);
        send_item(lspq_pkg::CMD_PUSH, 32'sd11, 32'sd7);
        send_item(lspq_pkg::CMD_PUSH, 32'sd12, 32'sd7);
        repeat (5) send_item(lspq_pkg::CMD_POP, '0, '0);
        send_item(lspq_pkg::CMD_PUSH, 32'sd1, 32'sd1);
        send_item(lspq_pkg::CMD_CLEAR, '0, '0);
        send_item(lspq_pkg::CMD_POP, '0, '0);

        // Zero capacity acts as one entry
        drain_replies();
        write_capacity(5'd0);
        send_item(lspq_pkg::CMD_PUSH, 32'sd21, 32'sd3);
        send_item(lspq_pkg::CMD_PUSH, 32'sd22, 32'sd4);
        send_item(lspq_pkg::CMD_POP, '0, '0);
        send_item(CMD_NOP, '0, '0);

        // Fill to the clamped maximum while the result side is held off
        drain_replies();
        write_capacity(5'd31);
        hold_req <= 1'b1;
        send_item(lspq_pkg::CMD_CLEAR, '0, '0);
        repeat (DEPTH + 1) send_item(lspq_pkg::CMD_PUSH, random_value(), random_priority());
        hold_req <= 1'b0;

        // Lower capacity below occupancy: pushes drop until pops make room
        drain_replies();
        write_capacity(5'd4);
        send_item(lspq_pkg::CMD_PUSH, random_value(), random_priority());
        repeat (DEPTH - 3) send_item(lspq_pkg::CMD_POP, '0, '0);
        send_item(lspq_pkg::CMD_PUSH, random_value(), random_priority());
        send_item(lspq_pkg::CMD_PUSH, random_value(), random_priority());

        // Random phases, each with its own capacity and push bias
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES / 3) begin
                src_idle_pct  = 61;
                sink_idle_pct = 23;
            end else if (phase == 2 * RANDOM_PHASES / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            drain_replies();
            write_capacity(phase_caps[phase]);
            push_pct = $urandom_range(70, 35);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_cmd(push_pct), random_value(), random_priority());
        end

        drain_replies();
        repeat (40) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lspq_pkg.sv
rtl/linear_scan_priority_queue.sv
test/lspq_queue_checker.sv
test/tb_linear_scan_priority_queue.sv
